### hw/rtl/mm8_pkg.sv
// Shared sizes, types and helpers for the 8x8 matrix multiplier.
// Depends on nothing; every other file of the block imports it.
package mm8_pkg;

  localparam int DIM          = 8;
  localparam int IDX_W        = $clog2(DIM);
  localparam int CELLS        = DIM * DIM;
  localparam int CELL_W       = 2 * IDX_W;
  localparam int BANKS        = 2;
  localparam int BANK_W       = 1;
  localparam int ADDR_W       = BANK_W + CELL_W;
  localparam int OPERAND_BITS = 16;
  localparam int PROD_W       = 2 * OPERAND_BITS;
  localparam int SUM_W        = 35;
  localparam int OUTQ_DEPTH   = 4;
  localparam int OUTQ_PTR_W   = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W   = OUTQ_PTR_W + 1;
  localparam int CMDQ_DEPTH   = 2;
  localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W   = CMDQ_PTR_W + 1;

  typedef logic signed [OPERAND_BITS-1:0] operand_t;

  // Write port of the operand store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    operand_t          left;
    operand_t          right;
  } store_wr_t;

  // Back end hands a bank back to the front end once all of its reads are issued.
  typedef struct packed {
    logic              vld;
    logic [BANK_W-1:0] bank;
  } bank_rel_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] value;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
  } result_t;

endpackage

### hw/rtl/mm8_store.sv
// Double-banked operand store: one array for A and one for B, one write
// port and one registered read port each. Depends on mm8_pkg.
module mm8_store import mm8_pkg::*; (
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic [ADDR_W-1:0] rd_addr_left,
  input  logic [ADDR_W-1:0] rd_addr_right,
  output operand_t          rd_left,
  output operand_t          rd_right
);

  localparam int WORDS = BANKS * CELLS;

  operand_t left_mem [WORDS];
  operand_t right_mem [WORDS];
  operand_t rd_left_r;
  operand_t rd_right_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      left_mem[wr.addr]  <= wr.left;
      right_mem[wr.addr] <= wr.right;
    end
    rd_left_r  <= left_mem[rd_addr_left];
    rd_right_r <= right_mem[rd_addr_right];
  end

  assign rd_left  = rd_left_r;
  assign rd_right = rd_right_r;

endmodule

### hw/rtl/mm8_cmdq.sv
// Short queue of finished-load commands (the bank to multiply) between the
// front and back ends. Depends on mm8_pkg.
module mm8_cmdq import mm8_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [BANK_W-1:0] push_bank,
  input  logic              pop,
  output logic              empty,
  output logic              full,
  output logic [BANK_W-1:0] head_bank
);

  logic [BANK_W-1:0]     mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign head_bank = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + CMDQ_PTR_W'(do_push);
    rd_ptr_nxt = rd_ptr_r + CMDQ_PTR_W'(do_pop);
    cnt_nxt    = cnt_r + CMDQ_CNT_W'(do_push) - CMDQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_bank;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("command queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("command queue popped while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CMDQ_CNT_W'(CMDQ_DEPTH))
    else $error("command queue count out of range");

endmodule

### hw/rtl/mm8_front.sv
// Front end: accepts operand pairs, writes them into the current bank of the
// store and queues a command once a matrix is complete. Depends on mm8_pkg.
module mm8_front import mm8_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  operand_t          in_left_value,
  input  operand_t          in_right_value,
  output store_wr_t         store_wr,
  output logic              cmd_push,
  output logic [BANK_W-1:0] cmd_bank,
  input  logic              cmd_full,
  input  bank_rel_t         bank_rel
);

  logic [CELL_W-1:0] load_cnt_r, load_cnt_nxt;
  logic [BANK_W-1:0] wr_bank_r, wr_bank_nxt;
  logic [BANKS-1:0]  busy_r, busy_nxt;
  logic              accept;
  logic              done;

  // A bank stays busy from its last load until the back end has read it out.
  assign full   = busy_r[wr_bank_r] || cmd_full;
  assign accept = push && !full;
  assign done   = accept && (load_cnt_r == CELL_W'(CELLS - 1));

  assign store_wr.en    = accept;
  assign store_wr.addr  = {wr_bank_r, load_cnt_r};
  assign store_wr.left  = in_left_value;
  assign store_wr.right = in_right_value;

  assign cmd_push = done;
  assign cmd_bank = wr_bank_r;

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    wr_bank_nxt  = wr_bank_r;
    busy_nxt     = busy_r;
    if (bank_rel.vld) begin
      busy_nxt[bank_rel.bank] = 1'b0;
    end
    if (accept) begin
      load_cnt_nxt = load_cnt_r + CELL_W'(1);
    end
    if (done) begin
      busy_nxt[wr_bank_r] = 1'b1;
      wr_bank_nxt         = wr_bank_r + BANK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      wr_bank_r  <= '0;
      busy_r     <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
      wr_bank_r  <= wr_bank_nxt;
      busy_r     <= busy_nxt;
    end
  end

  a_rel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bank_rel.vld |-> busy_r[bank_rel.bank])
    else $error("bank released that was not busy");
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    store_wr.en |-> !busy_r[wr_bank_r])
    else $error("write into a bank still being read");

endmodule

### hw/rtl/mm8_back.sv
// Back end: one shared multiply-accumulate unit walks row, column and inner
// index over a loaded bank; results go into a small output queue.
// Depends on mm8_pkg.
module mm8_back import mm8_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_empty,
  input  logic [BANK_W-1:0] cmd_bank,
  output logic              cmd_pop,
  output bank_rel_t         bank_rel,
  output logic [ADDR_W-1:0] rd_addr_left,
  output logic [ADDR_W-1:0] rd_addr_right,
  input  operand_t          rd_left,
  input  operand_t          rd_right,
  output logic              empty,
  input  logic              pop,
  output result_t           result
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  // Sequencer.
  logic              running_r, running_nxt;
  logic [BANK_W-1:0] bank_r, bank_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  // Read stage (store data valid) and product stage.
  logic             s1_vld_r, s1_first_r, s1_final_r, s1_last_r;
  logic [IDX_W-1:0] s1_row_r, s1_col_r;
  logic             s2_vld_r, s2_first_r, s2_final_r, s2_last_r;
  logic [IDX_W-1:0] s2_row_r, s2_col_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [SUM_W-1:0]  acc_r, sum;

  // Output queue.
  result_t               outq_mem_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] oq_wr_r, oq_rd_r;
  logic [OUTQ_CNT_W-1:0] oq_cnt_r, oq_cnt_nxt;
  logic [OUTQ_CNT_W-1:0] pending;
  logic                  oq_push, oq_pop;
  result_t               oq_in;

  logic issue, space_ok, end_entry, end_row, end_all;

  // An entry is started only if its result, plus those still in the pipe,
  // is sure to find room in the output queue.
  assign pending  = OUTQ_CNT_W'(s1_vld_r && s1_final_r) + OUTQ_CNT_W'(s2_vld_r && s2_final_r);
  assign space_ok = (oq_cnt_r + pending) < OUTQ_CNT_W'(OUTQ_DEPTH);
  assign issue    = running_r && ((k_r != '0) || space_ok);

  assign end_entry = (k_r == IDX_LAST);
  assign end_row   = end_entry && (j_r == IDX_LAST);
  assign end_all   = end_row && (i_r == IDX_LAST);

  assign rd_addr_left  = {bank_r, i_r, k_r};
  assign rd_addr_right = {bank_r, k_r, j_r};

  assign cmd_pop       = !running_r && !cmd_empty;
  assign bank_rel.vld  = issue && end_all;
  assign bank_rel.bank = bank_r;

  always_comb begin
    running_nxt = running_r;
    bank_nxt    = bank_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    if (cmd_pop) begin
      running_nxt = 1'b1;
      bank_nxt    = cmd_bank;
      i_nxt       = '0;
      j_nxt       = '0;
      k_nxt       = '0;
    end else if (issue) begin
      k_nxt = k_r + IDX_W'(1);
      if (end_entry) begin
        j_nxt = j_r + IDX_W'(1);
      end
      if (end_row) begin
        i_nxt = i_r + IDX_W'(1);
      end
      if (end_all) begin
        running_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
    end else begin
      running_r <= running_nxt;
      s1_vld_r  <= issue;
      s2_vld_r  <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    bank_r     <= bank_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    s1_first_r <= (k_r == '0);
    s1_final_r <= end_entry;
    s1_last_r  <= end_all;
    s1_row_r   <= i_r;
    s1_col_r   <= j_r;
    s2_first_r <= s1_first_r;
    s2_final_r <= s1_final_r;
    s2_last_r  <= s1_last_r;
    s2_row_r   <= s1_row_r;
    s2_col_r   <= s1_col_r;
    prod_r     <= prod_nxt;
    if (s2_vld_r) begin
      acc_r <= sum;
    end
  end

  assign prod_nxt = rd_left * rd_right;
  assign sum      = (s2_first_r ? SUM_W'(0) : acc_r) + SUM_W'(prod_r);

  assign oq_push     = s2_vld_r && s2_final_r;
  assign oq_in.value = sum;
  assign oq_in.row   = s2_row_r;
  assign oq_in.col   = s2_col_r;
  assign oq_in.last  = s2_last_r;

  assign empty  = (oq_cnt_r == '0);
  assign oq_pop = pop && !empty;
  assign result = outq_mem_r[oq_rd_r];

  assign oq_cnt_nxt = oq_cnt_r + OUTQ_CNT_W'(oq_push) - OUTQ_CNT_W'(oq_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wr_r  <= oq_wr_r + OUTQ_PTR_W'(oq_push);
      oq_rd_r  <= oq_rd_r + OUTQ_PTR_W'(oq_pop);
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      outq_mem_r[oq_wr_r] <= oq_in;
    end
  end

  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (oq_cnt_r < OUTQ_CNT_W'(OUTQ_DEPTH)) || oq_pop)
    else $error("output queue overflow");
  a_rel_end: assert property (@(posedge clk) disable iff (!rst_n)
    bank_rel.vld |=> !running_r)
    else $error("sequencer still running after its bank was released");
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_push && oq_in.last) |-> (oq_in.row == IDX_LAST) && (oq_in.col == IDX_LAST))
    else $error("last flag on an entry other than the final one");

endmodule

### hw/rtl/matrix_multiply_8x8.sv
// Top level of the 8x8 signed matrix multiplier (C = A times B).
// Depends on mm8_pkg, mm8_front, mm8_store, mm8_cmdq and mm8_back.
//
// Input: push/full queue. Each accepted word carries A[p] and B[p], p in
// row-major order. Words that do not complete a matrix give no result.
// Output: empty/pop queue. After the 64th word of a matrix, 64 words of
// C[i][j] (exact 35-bit sum of eight products) follow in row-major order,
// with out_row/out_col giving the position and out_last marking the 64th.
// Operands go into one of two store banks, so a new matrix loads while the
// previous one is being multiplied; full rises only when both banks wait.
// One multiply-accumulate unit does one product per cycle while the output
// queue has room; an entry is eight products, a matrix 512 and a bank swap.
// The completing word reaches the output through the command queue, the
// sequencer, the store read register, the product register and accumulator.
// A four-word output queue absorbs short stalls; when pop stays low the
// unit pauses between entries and no word is lost.
// Reset (rst_n low, synchronous) empties all queues and restarts loading at
// position 0; store contents are not cleared and need not be.
module matrix_multiply_8x8 import mm8_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic signed [15:0]      in_left_value,
  input  logic signed [15:0]      in_right_value,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [SUM_W-1:0] out_product_value,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic                    out_last
);

  store_wr_t         store_wr;
  bank_rel_t         bank_rel;
  logic              cmd_push, cmd_pop, cmd_empty, cmd_full;
  logic [BANK_W-1:0] cmd_bank_in, cmd_bank_out;
  logic [ADDR_W-1:0] rd_addr_left, rd_addr_right;
  operand_t          rd_left, rd_right;
  result_t           result;

  mm8_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_left_value  (in_left_value),
    .in_right_value (in_right_value),
    .store_wr       (store_wr),
    .cmd_push       (cmd_push),
    .cmd_bank       (cmd_bank_in),
    .cmd_full       (cmd_full),
    .bank_rel       (bank_rel)
  );

  mm8_store u_store (
    .clk           (clk),
    .wr            (store_wr),
    .rd_addr_left  (rd_addr_left),
    .rd_addr_right (rd_addr_right),
    .rd_left       (rd_left),
    .rd_right      (rd_right)
  );

  mm8_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_bank (cmd_bank_in),
    .pop       (cmd_pop),
    .empty     (cmd_empty),
    .full      (cmd_full),
    .head_bank (cmd_bank_out)
  );

  mm8_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_empty     (cmd_empty),
    .cmd_bank      (cmd_bank_out),
    .cmd_pop       (cmd_pop),
    .bank_rel      (bank_rel),
    .rd_addr_left  (rd_addr_left),
    .rd_addr_right (rd_addr_right),
    .rd_left       (rd_left),
    .rd_right      (rd_right),
    .empty         (empty),
    .pop           (pop),
    .result        (result)
  );

  assign out_product_value = result.value;
  assign out_row           = result.row;
  assign out_col           = result.col;
  assign out_last          = result.last;

endmodule

### sim/mm8_checker.sv
// Scoreboard for the 8x8 matrix multiplier: watches both queue ports,
// predicts every result word and compares it. Depends on mm8_pkg.
`timescale 1ns / 1ps

module mm8_checker import mm8_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic                    full,
  input  logic signed [15:0]      in_left_value,
  input  logic signed [15:0]      in_right_value,
  input  logic                    empty,
  input  logic                    pop,
  input  logic signed [SUM_W-1:0] out_product_value,
  input  logic [IDX_W-1:0]        out_row,
  input  logic [IDX_W-1:0]        out_col,
  input  logic                    out_last,
  output int                      fail_count,
  output int                      words_pending,
  output int                      results_seen
);

  operand_t left_mat [CELLS];
  operand_t right_mat [CELLS];
  int       load_pos;
  int       mismatches;
  int       seen;
  result_t  product_q [$];
  result_t  head_w;
  result_t  next_w;

  // Exact sum of eight products; the 64-bit signed context extends both operands.
  function automatic logic signed [SUM_W-1:0] entry_sum(int row_i, int col_j);
    logic signed [63:0] acc;
    acc = '0;
    for (int k = 0; k < DIM; k++)
      acc = acc + left_mat[row_i*DIM + k] * right_mat[k*DIM + col_j];
    return acc[SUM_W-1:0];
  endfunction

  initial begin
    load_pos   = 0;
    mismatches = 0;
    seen       = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      load_pos = 0;
      product_q.delete();
    end else begin
      if (pop && !empty) begin
        seen++;
        if (product_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing expected: value %0d row %0d col %0d last %0b",
                     $time, out_product_value, out_row, out_col, out_last);
        end else begin
          head_w = product_q.pop_front();
          if (out_product_value !== head_w.value || out_row !== head_w.row ||
              out_col !== head_w.col || out_last !== head_w.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected %0d row %0d col %0d last %0b, got %0d row %0d col %0d last %0b",
                       $time, head_w.value, head_w.row, head_w.col, head_w.last,
                       out_product_value, out_row, out_col, out_last);
          end
        end
      end
      if (push && !full) begin
        left_mat[load_pos]  = in_left_value;
        right_mat[load_pos] = in_right_value;
        load_pos++;
        // The word that completes a matrix releases all 64 entries of C.
        if (load_pos == CELLS) begin
          load_pos = 0;
          for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
              next_w.value = entry_sum(i, j);
              next_w.row   = IDX_W'(i);
              next_w.col   = IDX_W'(j);
              next_w.last  = (i == DIM - 1) && (j == DIM - 1);
              product_q.push_back(next_w);
            end
          end
        end
      end
    end
    fail_count    <= mismatches;
    words_pending <= product_q.size();
    results_seen  <= seen;
  end

endmodule

### sim/matrix_multiply_8x8_tb.sv
// Testbench top for matrix_multiply_8x8: drives operand words, pops results
// with random stalls and gives the verdict. Depends on mm8_pkg and mm8_checker.
`timescale 1ns / 1ps

module matrix_multiply_8x8_tb;
  import mm8_pkg::*;

  localparam int TOTAL_WORDS      = 2 * CELLS + 32;
  localparam int DIRECTED_WORDS   = 24;
  localparam int HOLD_START       = CELLS;
  localparam int DRAIN_AT         = 2 * CELLS + 8;
  localparam int QUIET_FROM       = 150;
  localparam int LONG_HOLD_CYCLES = 1000;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int SETTLE_CYCLES    = 40;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    push;
  logic                    full;
  logic signed [15:0]      in_left_value;
  logic signed [15:0]      in_right_value;
  logic                    empty;
  logic                    pop;
  logic signed [SUM_W-1:0] out_product_value;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic                    out_last;

  int   fail_count;
  int   words_pending;
  int   results_seen;
  int   words_taken;
  int   stall_cycles;
  logic hold_request;
  logic quiet;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  matrix_multiply_8x8 uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_left_value     (in_left_value),
    .in_right_value    (in_right_value),
    .empty             (empty),
    .pop               (pop),
    .out_product_value (out_product_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last          (out_last)
  );

  mm8_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_left_value     (in_left_value),
    .in_right_value    (in_right_value),
    .empty             (empty),
    .pop               (pop),
    .out_product_value (out_product_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .words_pending     (words_pending),
    .results_seen      (results_seen)
  );

  function automatic logic [15:0] edge_value(int sel);
    case (sel % 8)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      5: return 16'h5555;
      6: return 16'hAAAA;
      default: return 16'hFFFE;
    endcase
  endfunction

  function automatic logic [15:0] mixed_operand();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6)
      return 16'($urandom);
    else if (sel < 8)
      return edge_value($urandom_range(0, 7));
    else
      return 16'($urandom_range(0, 16)) - 16'd8;
  endfunction

  // Offers one word and returns at the edge where it was taken.
  task automatic offer_word(input logic [15:0] a, input logic [15:0] b);
    push           <= 1'b1;
    in_left_value  <= a;
    in_right_value <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Sender.
  initial begin
    int          n;
    int          pos;
    int          gap;
    int          gap_odds;
    logic [15:0] a;
    logic [15:0] b;
    rst_n          <= 1'b0;
    push           <= 1'b0;
    in_left_value  <= '0;
    in_right_value <= '0;
    hold_request   <= 1'b0;
    quiet          <= 1'b0;
    gap_odds       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (n = 0; n < TOTAL_WORDS; n++) begin
      pos = n % CELLS;
      if (n % 32 == 0) begin
        case ($urandom_range(0, 3))
          0: gap_odds = 0;
          1: gap_odds = 3;
          2: gap_odds = 6;
          default: gap_odds = 10;
        endcase
      end
      if (n == HOLD_START) hold_request <= 1'b1;
      if (n == QUIET_FROM) quiet <= 1'b1;
      if (n == DRAIN_AT) begin
        push <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
      end else if (n >= DIRECTED_WORDS && n < QUIET_FROM && gap_odds != 0 &&
                   $urandom_range(1, gap_odds) == 1) begin
        // Idle burst; the data lines carry junk while push is low.
        gap = $urandom_range(1, 19);
        push           <= 1'b0;
        in_left_value  <= 16'($urandom);
        in_right_value <= 16'($urandom);
        repeat (gap) @(posedge clk);
      end
      if (n < DIRECTED_WORDS) begin
        a = edge_value(n);
        b = edge_value(n / 8 + 3 * n);
      end else if (n < CELLS) begin
        a = mixed_operand();
        b = mixed_operand();
      end else if (n < 2 * CELLS) begin
        // All of A at the negative extreme; B columns 0-3 likewise, 4-7 at the
        // positive extreme, so C holds both the largest and smallest sums.
        a = 16'h8000;
        b = (pos % DIM < DIM / 2) ? 16'h8000 : 16'h7FFF;
      end else begin
        a = mixed_operand();
        b = mixed_operand();
      end
      offer_word(a, b);
    end
    push <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d operand words (%0d full matrices plus a partial one),",
             words_taken, words_taken / CELLS);
    $display("checked %0d result words, with extreme sums, a long output stall",
             results_seen);
    $display("that filled the block, and a drain pause.");
    if (fail_count == 0 && words_pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off, none near the end.
  initial begin
    int  stall_left;
    logic hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (hold_request && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: cycles in a row in which neither port moves a word.
  initial begin
    stall_cycles = 0;
    words_taken  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && push && !full) words_taken++;
      if (!rst_n || (push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("Timeout after %0d cycles without a handshake", stall_cycles);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

endmodule
